>>> sv/wccg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wccg_pkg
// Shared types and codes of the word chain candidate generator.
// ----------------------------------------------------------------------------
package wccg_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SEEK = 2'd1;
    localparam logic [1:0] OP_NEXT = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] CFG_CAND_LEN = 2'd0;
    localparam logic [1:0] CFG_SPLIT    = 2'd1;
    localparam logic [1:0] CFG_MIN_EL   = 2'd2;
    localparam logic [1:0] CFG_MAX_EL   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  word_length;
        logic [63:0] word_low;
        logic [63:0] word_high;
        logic [63:0] position;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] candidate_low;
        logic [63:0] candidate_high;
        logic [4:0]  candidate_bytes;
        logic        wrapped;
    } t_out_word;

    typedef struct packed {
        logic    capture;
        logic    load_word;
        logic    dec_step;
        logic    chk_step;
        logic    seek_init;
        logic    next_init;
        logic    div_start;
        logic    seek_store;
        logic    next_rd;
        logic    next_acc;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] opcode;
        logic       load_bad;
        logic       len_bad;
        logic       dec_done;
        logic       chk_empty;
        logic       elem_last;
        logic       range_bad;
        logic       div_done;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> sv/wccg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wccg_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module wccg_div #(
    parameter int CW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [63:0]   i_dividend,
    input  wire logic [CW-1:0] i_divisor,
    output logic               o_done,
    output logic [63:0]        o_quot,
    output logic [CW-1:0]      o_rem
);

    logic          r_busy, r_done;
    logic [5:0]    r_step;
    logic [63:0]   r_q;
    logic [CW-1:0] r_r, r_div;
    logic [CW:0]   trial, diff;
    logic          take;

    assign trial = {r_r, r_q[63]};
    assign diff  = trial - {1'b0, r_div};
    assign take  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_step == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_r <= take ? diff[CW-1:0] : trial[CW-1:0];
            r_q <= {r_q[62:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule
`default_nettype wire

>>> sv/wccg_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wccg_dp
// Datapath: configuration, word stores, chain decode, odometer, candidate.
// ----------------------------------------------------------------------------
module wccg_dp #(
    parameter int WORDS_PER_LENGTH = 1024,
    parameter int MAX_WORD_LENGTH  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wccg_pkg::t_in_word i_in_data,
    input  wire logic               i_cfg_valid,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [14:0]        i_cfg_data,
    input  wire wccg_pkg::t_dp_cmd  i_cmd,
    output wccg_pkg::t_dp_stat      o_stat,
    output wccg_pkg::t_out_word     o_out_data
);

    localparam int CW    = $clog2(WORDS_PER_LENGTH + 1);
    localparam int DW    = (WORDS_PER_LENGTH > 1) ? $clog2(WORDS_PER_LENGTH) : 1;
    localparam int LIW   = (MAX_WORD_LENGTH > 1) ? $clog2(MAX_WORD_LENGTH) : 1;
    localparam int DEPTH = MAX_WORD_LENGTH * WORDS_PER_LENGTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [4:0]  r_cand_len, r_min_el, r_max_el;
    logic [14:0] r_split;
    logic [CW-1:0] r_cnt [MAX_WORD_LENGTH];
    logic [DW-1:0] r_dig [MAX_WORD_LENGTH];
    logic [4:0]    r_lens [MAX_WORD_LENGTH];
    logic [127:0]  r_mem [DEPTH];

    wccg_pkg::t_in_word  r_item;
    wccg_pkg::t_status   r_status;
    wccg_pkg::t_out_word r_out;
    logic [3:0]     r_s;
    logic [4:0]     r_run, r_n, r_p;
    logic [LIW-1:0] r_idx;
    logic [63:0]    r_pos;
    logic [127:0]   r_cand, r_rd_data;
    logic           r_carry;

    logic           len_ok, full, load_bad;
    logic [LIW-1:0] load_idx, el_idx;
    logic [CW-1:0]  ld_cnt, el_cnt, d_inc;
    logic [4:0]     cur_len;
    logic [DW-1:0]  cur_dig, d_eff;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic           dec_done, inc_fits;
    logic [127:0]   msk, part;
    logic           div_done;
    logic [63:0]    div_quot;
    logic [CW-1:0]  div_rem;

    assign len_ok   = (r_item.word_length != 5'd0) &&
                      (r_item.word_length <= 5'(MAX_WORD_LENGTH));
    assign load_idx = LIW'(r_item.word_length - 5'd1);
    assign ld_cnt   = r_cnt[load_idx];
    assign full     = ld_cnt >= CW'(WORDS_PER_LENGTH);
    assign load_bad = !len_ok || full;

    assign cur_len  = r_lens[r_idx];
    assign el_idx   = LIW'(cur_len - 5'd1);
    assign el_cnt   = r_cnt[el_idx];
    assign cur_dig  = r_dig[r_idx];
    // stale digit from an earlier configuration counts as zero
    assign d_eff    = (CW'(cur_dig) >= el_cnt) ? '0 : cur_dig;
    assign d_inc    = CW'(d_eff) + CW'(1);
    assign inc_fits = d_inc < el_cnt;

    assign wr_addr  = AW'(load_idx) * AW'(WORDS_PER_LENGTH) + AW'(ld_cnt);
    assign rd_addr  = AW'(el_idx) * AW'(WORDS_PER_LENGTH) + AW'(d_eff);

    assign dec_done = (5'(r_s) + 5'd1) >= r_cand_len;
    assign msk      = ~({128{1'b1}} << {cur_len, 3'b000});
    assign part     = (r_rd_data & msk) << {r_p[3:0], 3'b000};

    wccg_div #(.CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_pos),
        .i_divisor  (el_cnt),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        o_stat.opcode    = r_item.opcode;
        o_stat.load_bad  = load_bad;
        o_stat.len_bad   = (r_cand_len == 5'd0) || (r_cand_len > 5'(MAX_WORD_LENGTH));
        o_stat.dec_done  = dec_done;
        o_stat.chk_empty = el_cnt == '0;
        o_stat.elem_last = 5'(r_idx) == (r_n - 5'd1);
        o_stat.range_bad = (r_n < r_min_el) || (r_n > r_max_el);
        o_stat.div_done  = div_done;
    end

    // control state: configuration, word counts, odometer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_len <= 5'd1;
            r_split    <= '0;
            r_min_el   <= 5'd1;
            r_max_el   <= 5'd8;
            for (int i = 0; i < MAX_WORD_LENGTH; i++) begin
                r_cnt[i] <= '0;
                r_dig[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wccg_pkg::CFG_CAND_LEN: r_cand_len <= i_cfg_data[4:0];
                    wccg_pkg::CFG_SPLIT:    r_split    <= i_cfg_data;
                    wccg_pkg::CFG_MIN_EL:   r_min_el   <= i_cfg_data[4:0];
                    wccg_pkg::CFG_MAX_EL:   r_max_el   <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_word && !load_bad) begin
                r_cnt[load_idx] <= ld_cnt + CW'(1);
            end
            if (i_cmd.seek_init) begin
                for (int i = 0; i < MAX_WORD_LENGTH; i++) begin
                    r_dig[i] <= '0;
                end
            end
            if (i_cmd.seek_store) begin
                r_dig[r_idx] <= DW'(div_rem);
            end
            if (i_cmd.next_rd) begin
                if (r_carry) begin
                    r_dig[r_idx] <= inc_fits ? DW'(d_inc) : '0;
                end else begin
                    r_dig[r_idx] <= d_eff;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word && !load_bad) begin
            r_mem[wr_addr] <= {r_item.word_high, r_item.word_low};
        end
        if (i_cmd.next_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= i_in_data;
            r_status <= wccg_pkg::ST_OK;
            r_s      <= '0;
            r_run    <= 5'd1;
            r_n      <= '0;
            r_idx    <= '0;
            r_cand   <= '0;
            r_p      <= '0;
            r_carry  <= 1'b0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.dec_step) begin
            if (!dec_done) begin
                if (r_split[r_s]) begin
                    r_lens[r_n[LIW-1:0]] <= r_run;
                    r_n   <= r_n + 5'd1;
                    r_run <= 5'd1;
                end else begin
                    r_run <= r_run + 5'd1;
                end
                r_s <= r_s + 4'd1;
            end else begin
                r_lens[r_n[LIW-1:0]] <= r_run;
                r_n <= r_n + 5'd1;
            end
        end
        if (i_cmd.chk_step) begin
            r_idx <= r_idx + LIW'(1);
        end
        if (i_cmd.seek_init) begin
            r_idx <= '0;
            r_pos <= r_item.position;
        end
        if (i_cmd.next_init) begin
            r_idx   <= '0;
            r_carry <= 1'b1;
        end
        if (i_cmd.seek_store) begin
            r_pos <= div_quot;
            r_idx <= r_idx + LIW'(1);
        end
        if (i_cmd.next_rd && r_carry && inc_fits) begin
            r_carry <= 1'b0;
        end
        if (i_cmd.next_acc) begin
            r_cand <= r_cand | part;
            r_p    <= r_p + cur_len;
            r_idx  <= r_idx + LIW'(1);
        end
        if (i_cmd.out_load) begin
            r_out.status          <= r_status;
            r_out.candidate_low   <= r_cand[63:0];
            r_out.candidate_high  <= r_cand[127:64];
            r_out.candidate_bytes <= r_p;
            r_out.wrapped         <= r_carry;
        end
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

>>> sv/wccg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wccg_ctrl
// Sequencer: decode, check, seek and next phases; output handshake.
// ----------------------------------------------------------------------------
module wccg_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire wccg_pkg::t_dp_stat i_stat,
    output wccg_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DISPATCH  = 9'b000000010,
        S_DECODE    = 9'b000000100,
        S_CHECK     = 9'b000001000,
        S_SEEK_DIV  = 9'b000010000,
        S_SEEK_WAIT = 9'b000100000,
        S_NEXT_RD   = 9'b001000000,
        S_NEXT_ACC  = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.opcode)
                    wccg_pkg::OP_LOAD: begin
                        o_cmd.load_word = 1'b1;
                        if (i_stat.load_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = wccg_pkg::ST_FULL;
                        end
                        n_state = S_DONE;
                    end
                    wccg_pkg::OP_NONE: n_state = S_DONE;
                    default: begin
                        if (i_stat.len_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = wccg_pkg::ST_RANGE;
                            n_state          = S_DONE;
                        end else begin
                            n_state = S_DECODE;
                        end
                    end
                endcase
            end
            S_DECODE: begin
                o_cmd.dec_step = 1'b1;
                if (i_stat.dec_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.chk_empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = wccg_pkg::ST_EMPTY;
                    n_state          = S_DONE;
                end else if (!i_stat.elem_last) begin
                    o_cmd.chk_step = 1'b1;
                end else if (i_stat.range_bad) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = wccg_pkg::ST_RANGE;
                    n_state          = S_DONE;
                end else if (i_stat.opcode == wccg_pkg::OP_SEEK) begin
                    o_cmd.seek_init = 1'b1;
                    n_state         = S_SEEK_DIV;
                end else begin
                    o_cmd.next_init = 1'b1;
                    n_state         = S_NEXT_RD;
                end
            end
            S_SEEK_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_SEEK_WAIT;
            end
            S_SEEK_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.seek_store = 1'b1;
                    n_state          = i_stat.elem_last ? S_DONE : S_SEEK_DIV;
                end
            end
            S_NEXT_RD: begin
                o_cmd.next_rd = 1'b1;
                n_state       = S_NEXT_ACC;
            end
            S_NEXT_ACC: begin
                o_cmd.next_acc = 1'b1;
                n_state        = i_stat.elem_last ? S_DONE : S_NEXT_RD;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> sv/word_chain_candidate_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// word_chain_candidate_generator_unit
// Per-length word stores with a mixed-radix odometer that chains words into
// candidates; loads, seeks and next-candidate words share one input channel.
// ----------------------------------------------------------------------------
// Sequencing: a load or unused opcode goes from dispatch straight to the result;
//   next and seek decode the chain and check its elements, then next reads and
//   accumulates element by element through the store's single read port.
// Throughput: one word in flight; the next input is taken once the result
//   sits in the output register, even while that result is still stalled.
// Reset (i_rst_n low, synchronous): stores empty, odometer zero, config back
//   to defaults; store contents are left as they are, no clearing pass.
// ----------------------------------------------------------------------------
module word_chain_candidate_generator_unit #(
    parameter int WORDS_PER_LENGTH = 1024,
    parameter int MAX_WORD_LENGTH  = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input words
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire wccg_pkg::t_in_word  i_in_data,
    // result words
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output wccg_pkg::t_out_word      o_out_data,
    // configuration writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [14:0]         i_cfg_data
);

    wccg_pkg::t_dp_cmd  cmd;
    wccg_pkg::t_dp_stat stat;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: owns the input and output handshakes and steps the datapath
    wccg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: stores, chain decode, odometer, divider and result register
    wccg_dp #(
        .WORDS_PER_LENGTH (WORDS_PER_LENGTH),
        .MAX_WORD_LENGTH  (MAX_WORD_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // a candidate is only ever given with an ok status
    a_cand_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.candidate_bytes != 5'd0)
            |-> (o_out_data.status == wccg_pkg::ST_OK))
        else $error("candidate given with error status");

    // wrap is reported only alongside a candidate
    a_wrap_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.wrapped |-> (o_out_data.candidate_bytes != 5'd0))
        else $error("wrap without candidate");

    // candidate never longer than the longest word
    a_cand_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.candidate_bytes <= 5'(MAX_WORD_LENGTH)))
        else $error("candidate length overflow");

    // after a word is accepted, the input is stalled in the next cycle
    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");
`endif

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the word chain candidate generator: words, seeks
// and next requests are driven with random idling on both channels, and each
// result word is checked against a predictor of the stores and odometer.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WPL      = 1024;
    localparam int MAXLEN   = 16;
    localparam int LIMIT    = 4000000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    wccg_pkg::t_in_word   i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    wccg_pkg::t_out_word  o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index = '0;
    logic [14:0]          i_cfg_data = '0;

    word_chain_candidate_generator_unit #(
        .WORDS_PER_LENGTH(WPL),
        .MAX_WORD_LENGTH (MAXLEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: configuration, per-length stores and the odometer.
    logic [4:0]  cand_len;
    logic [14:0] split_bits;
    logic [4:0]  min_el;
    logic [4:0]  max_el;
    int unsigned words_held [MAXLEN];
    logic [63:0] store_lo [MAXLEN][WPL];
    logic [63:0] store_hi [MAXLEN][WPL];
    int unsigned digit [MAXLEN];

    wccg_pkg::t_out_word expected_q [$];
    int          fail_count = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;      // no idling on either side
    int          hold_left = 0;     // receiver hold-off still to run

    // Decode the chain of element lengths and return its status.
    function automatic wccg_pkg::t_status decode_chain(output int lens [MAXLEN],
                                                       output int n);
        int run;
        n = 0;
        run = 1;
        for (int i = 0; i < MAXLEN; i++) lens[i] = 0;
        if (cand_len < 1 || cand_len > MAXLEN) return wccg_pkg::ST_RANGE;
        for (int s = 0; s + 1 < cand_len; s++) begin
            if (split_bits[s]) begin
                lens[n] = run;
                n++;
                run = 1;
            end else begin
                run++;
            end
        end
        lens[n] = run;
        n++;
        for (int i = 0; i < n; i++)
            if (words_held[lens[i]-1] == 0) return wccg_pkg::ST_EMPTY;
        if (n < min_el || n > max_el) return wccg_pkg::ST_RANGE;
        return wccg_pkg::ST_OK;
    endfunction

    // Work out the result word of one accepted input word and advance state.
    function automatic wccg_pkg::t_out_word chain_result(wccg_pkg::t_in_word w);
        wccg_pkg::t_out_word r;
        wccg_pkg::t_status   st;
        int          lens [MAXLEN];
        int          n;
        int          p;
        int          len;
        logic [63:0] pos;
        logic [127:0] cand;
        logic [127:0] wd;
        bit          carry;
        r = '0;
        if (w.opcode == wccg_pkg::OP_LOAD) begin
            len = w.word_length;
            if (len < 1 || len > MAXLEN || words_held[len-1] >= WPL) begin
                r.status = wccg_pkg::ST_FULL;
            end else begin
                store_lo[len-1][words_held[len-1]] = w.word_low;
                store_hi[len-1][words_held[len-1]] = w.word_high;
                words_held[len-1]++;
            end
            return r;
        end
        if (w.opcode == wccg_pkg::OP_NONE) return r;
        st = decode_chain(lens, n);
        if (st != wccg_pkg::ST_OK) begin
            r.status = st;
            return r;
        end
        if (w.opcode == wccg_pkg::OP_SEEK) begin
            pos = w.position;
            for (int i = 0; i < MAXLEN; i++) begin
                if (i < n) begin
                    digit[i] = int'(pos % 64'(words_held[lens[i]-1]));
                    pos = pos / 64'(words_held[lens[i]-1]);
                end else begin
                    digit[i] = 0;
                end
            end
            return r;
        end
        // next: concatenate the selected words, then step the odometer
        cand = '0;
        p = 0;
        for (int i = 0; i < n; i++) begin
            if (digit[i] >= words_held[lens[i]-1]) digit[i] = 0;
            wd = {store_hi[lens[i]-1][digit[i]], store_lo[lens[i]-1][digit[i]]};
            for (int b = 0; b < lens[i]; b++)
                if (p + b < 16) cand[8*(p+b) +: 8] = wd[8*b +: 8];
            p += lens[i];
        end
        carry = 1'b1;
        for (int i = 0; i < n && carry; i++) begin
            if (digit[i] + 1 < words_held[lens[i]-1]) begin
                digit[i]++;
                carry = 1'b0;
            end else begin
                digit[i] = 0;
            end
        end
        r.candidate_low   = cand[63:0];
        r.candidate_high  = cand[127:64];
        r.candidate_bytes = 5'(p);
        r.wrapped         = carry;
        return r;
    endfunction

    // Offer one word, at times after a random gap, and hold it until taken.
    task automatic send_word(wccg_pkg::t_in_word w);
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 28) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_in_data  = w;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_q.push_back(chain_result(w));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        wait (expected_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    // Write one register once the block has gone idle.
    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            wccg_pkg::CFG_CAND_LEN: cand_len   = val[4:0];
            wccg_pkg::CFG_SPLIT:    split_bits = val;
            wccg_pkg::CFG_MIN_EL:   min_el     = val[4:0];
            wccg_pkg::CFG_MAX_EL:   max_el     = val[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_chain(logic [14:0] clen, logic [14:0] split,
                             logic [14:0] lo, logic [14:0] hi);
        write_reg(wccg_pkg::CFG_CAND_LEN, clen);
        write_reg(wccg_pkg::CFG_SPLIT, split);
        write_reg(wccg_pkg::CFG_MIN_EL, lo);
        write_reg(wccg_pkg::CFG_MAX_EL, hi);
    endtask

    function automatic wccg_pkg::t_in_word mk(logic [1:0] op, logic [4:0] len,
                                              logic [63:0] lo, logic [63:0] hi,
                                              logic [63:0] pos);
        wccg_pkg::t_in_word w;
        w.opcode = op;
        w.word_length = len;
        w.word_low = lo;
        w.word_high = hi;
        w.position = pos;
        return w;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Empty stores, bad lengths, extremes of the word fields, a short chain
    // that wraps, and the error cases of the chain configuration.
    task automatic test_directed();
        send_word(mk(wccg_pkg::OP_NEXT, 5'd0, '0, '0, '0));
        send_word(mk(wccg_pkg::OP_LOAD, 5'd0, '1, '1, '1));
        send_word(mk(wccg_pkg::OP_LOAD, 5'd31, '1, '1, '0));
        send_word(mk(wccg_pkg::OP_LOAD, 5'd17, '0, '0, '0));
        send_word(mk(wccg_pkg::OP_NONE, 5'd1, '1, '1, '1));
        send_word(mk(wccg_pkg::OP_LOAD, 5'd1, 64'h41, '0, '0));
        send_word(mk(wccg_pkg::OP_LOAD, 5'd1, '1, '1, '0));
        send_word(mk(wccg_pkg::OP_LOAD, 5'd16, '1, '1, '0));
        send_word(mk(wccg_pkg::OP_LOAD, 5'd16, '0, '0, '0));
        set_chain(15'd2, 15'h0001, 15'd1, 15'd2);
        repeat (5) send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
        send_word(mk(wccg_pkg::OP_SEEK, '0, '0, '0, '1));
        send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
        // Drop min above the chain, then min above max.
        write_reg(wccg_pkg::CFG_MIN_EL, 15'd3);
        send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
        write_reg(wccg_pkg::CFG_MIN_EL, 15'd16);
        write_reg(wccg_pkg::CFG_MAX_EL, 15'd1);
        send_word(mk(wccg_pkg::OP_SEEK, '0, '0, '0, '0));
        // Candidate length out of range, both ways.
        set_chain(15'd0, 15'h7FFF, 15'd1, 15'd16);
        send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
        write_reg(wccg_pkg::CFG_CAND_LEN, 15'h7FF1);
        send_word(mk(wccg_pkg::OP_SEEK, '0, '0, '0, '1));
        // Whole-width single element, and an empty element length.
        write_reg(wccg_pkg::CFG_CAND_LEN, 15'd16);
        write_reg(wccg_pkg::CFG_SPLIT, 15'h0000);
        send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
        send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
        write_reg(wccg_pkg::CFG_SPLIT, 15'h0100);
        send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
    endtask

    function automatic wccg_pkg::t_in_word random_word();
        int k;
        logic [4:0] len;
        k = $urandom_range(99);
        if (k < 18) begin
            len = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 17))
                  : ($urandom_range(29) == 0) ? 5'd0 : 5'($urandom_range(16, 1));
            return mk(wccg_pkg::OP_LOAD, len, rnd64(), rnd64(), rnd64());
        end
        if (k < 26)
            return mk(wccg_pkg::OP_SEEK, 5'($urandom()), rnd64(), rnd64(),
                      $urandom_range(1) ? rnd64() : 64'($urandom_range(40)));
        if (k < 29)
            return mk(wccg_pkg::OP_NONE, 5'($urandom()), rnd64(), rnd64(), rnd64());
        return mk(wccg_pkg::OP_NEXT, 5'($urandom()), rnd64(), rnd64(), rnd64());
    endfunction

    // Phases of random words, each under a fresh chain configuration.
    task automatic test_random();
        logic [14:0] clen;
        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph == 4);
            if (ph == 9) begin
                set_chain(15'd16, 15'h7FFF, 15'd16, 15'd16);
            end else begin
                clen = ($urandom_range(9) == 0) ? 15'($urandom_range(31, 17))
                       : 15'($urandom_range(6, 1) + ($urandom_range(3) == 0 ? 10 : 0));
                set_chain(clen | 15'($urandom_range(1023) << 5), 15'($urandom()),
                          15'($urandom_range(3, 1)), 15'($urandom_range(16, 4)));
            end
            for (int i = 0; i < 5; i++) send_word(random_word());
        end
        quiet = 1'b0;
    endtask

    // Hold the receiver off while words keep coming, then pause for drain.
    task automatic test_backpressure();
        set_chain(15'd3, 15'h0003, 15'd1, 15'd8);
        hold_left = 400;
        for (int i = 0; i < 25; i++)
            send_word(mk($urandom_range(1) ? wccg_pkg::OP_NEXT : wccg_pkg::OP_LOAD, 5'd1,
                         rnd64(), rnd64(), '0));
        wait (expected_q.size() == 0);
        for (int i = 0; i < 10; i++) send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
    endtask

    // Fill the longest-word store to the brim with no idling, then load past it.
    task automatic test_store_full();
        quiet = 1'b1;
        while (words_held[MAXLEN-1] < WPL)
            send_word(mk(wccg_pkg::OP_LOAD, 5'd16, rnd64(), rnd64(), '0));
        quiet = 1'b0;
        for (int i = 0; i < 3; i++)
            send_word(mk(wccg_pkg::OP_LOAD, 5'd16, rnd64(), rnd64(), '0));
        set_chain(15'd16, 15'h0000, 15'd1, 15'd1);
        send_word(mk(wccg_pkg::OP_SEEK, '0, '0, '0, '1));
        for (int i = 0; i < 4; i++) send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
        send_word(mk(wccg_pkg::OP_SEEK, '0, '0, '0, 64'(WPL - 1)));
        send_word(mk(wccg_pkg::OP_NEXT, '0, '0, '0, '0));
    endtask

    // Receiver: random stall, or a counted hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 28);
        end
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        wccg_pkg::t_out_word exp_w;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                exp_w = expected_q.pop_front();
                if (o_out_data.status !== exp_w.status) begin
                    $error("status: expected %0d, got %0d", exp_w.status, o_out_data.status);
                    fail_count++;
                end
                if (o_out_data.candidate_low !== exp_w.candidate_low) begin
                    $error("candidate_low: expected %h, got %h",
                           exp_w.candidate_low, o_out_data.candidate_low);
                    fail_count++;
                end
                if (o_out_data.candidate_high !== exp_w.candidate_high) begin
                    $error("candidate_high: expected %h, got %h",
                           exp_w.candidate_high, o_out_data.candidate_high);
                    fail_count++;
                end
                if (o_out_data.candidate_bytes !== exp_w.candidate_bytes) begin
                    $error("candidate_bytes: expected %0d, got %0d",
                           exp_w.candidate_bytes, o_out_data.candidate_bytes);
                    fail_count++;
                end
                if (o_out_data.wrapped !== exp_w.wrapped) begin
                    $error("wrapped: expected %0d, got %0d", exp_w.wrapped, o_out_data.wrapped);
                    fail_count++;
                end
            end
        end
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        if (cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        cand_len   = 5'd1;
        split_bits = '0;
        min_el     = 5'd1;
        max_el     = 5'd8;
        for (int i = 0; i < MAXLEN; i++) begin
            words_held[i] = 0;
            digit[i]      = 0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        test_store_full();
        wait (expected_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
